@@ rtl/dge_pkg.sv @@
// Shared types and constants of the diagonal gradient edge unit.
package dge_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 11;
  localparam int PIX_W      = 24;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int POS_W      = 10;
  localparam int EDGE_W     = 8;
  localparam int KSUM_W     = 11;
  localparam int TOT_W      = 18;
  localparam int OBUF_DEPTH = 8;
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);
  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(3);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
  localparam logic [POS_W-1:0] ROW_LIMIT   = POS_W'(1023);
  localparam logic [TOT_W-1:0] EDGE_LIMIT  = TOT_W'(255);

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_value;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic s1_busy;
    logic win_busy;
  } lw_status_t;

endpackage

@@ rtl/dge_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module dge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dge_line_window.sv @@
// Position counters, line memory read-modify-write and the 3x3 pixel window.
module dge_line_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [dge_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_fire,
  input  dge_pkg::pixel_t           in_pixel,
  input  logic                      in_sof,
  output dge_pkg::window_t          win,
  output logic                      win_valid,
  output dge_pkg::meta_t            win_meta,
  output dge_pkg::lw_status_t       status
);

  logic [dge_pkg::CFG_W-1:0] frame_width_r;
  logic [dge_pkg::CFG_W-1:0] eff_w;
  logic [dge_pkg::COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [dge_pkg::POS_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [dge_pkg::COL_W-1:0] col_cur;
  logic [dge_pkg::POS_W-1:0] row_cur;
  logic                      line_end;
  logic                      emit;

  logic                      clr_busy_r;
  logic [dge_pkg::COL_W-1:0] clr_addr_r;

  logic                        s1_v_r;
  logic                        s1_emit_r;
  dge_pkg::pixel_t             s1_px_r;
  logic [dge_pkg::COL_W-1:0]   s1_col_r;
  dge_pkg::meta_t              s1_meta_r;
  logic                        fwd_r;
  logic [dge_pkg::LINE_W-1:0]  fwd_data_r;

  logic [dge_pkg::LINE_W-1:0]  ram_rdata;
  logic [dge_pkg::LINE_W-1:0]  line_data;
  logic [dge_pkg::LINE_W-1:0]  wr_line;
  dge_pkg::pixel_t             up1, up2;
  logic                        ram_we;
  logic [dge_pkg::COL_W-1:0]   ram_waddr;
  logic [dge_pkg::LINE_W-1:0]  ram_wdata;

  dge_pkg::window_t          win_r;
  logic                      w_v_r;
  dge_pkg::meta_t            w_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= dge_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      frame_width_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (frame_width_r < dge_pkg::WIDTH_MIN) begin
      eff_w = dge_pkg::WIDTH_MIN;
    end else if (frame_width_r > dge_pkg::WIDTH_MAX) begin
      eff_w = dge_pkg::WIDTH_MAX;
    end else begin
      eff_w = frame_width_r;
    end
  end

  assign col_cur  = in_sof ? '0 : col_cnt_r;
  assign row_cur  = in_sof ? '0 : row_cnt_r;
  assign line_end = (dge_pkg::CFG_W'(col_cur) + dge_pkg::CFG_W'(1)) >= eff_w;
  assign emit     = (row_cur >= dge_pkg::POS_W'(2)) && (col_cur >= dge_pkg::COL_W'(2));

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_fire) begin
      if (line_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_cur < dge_pkg::ROW_LIMIT) ? row_cur + dge_pkg::POS_W'(1) : row_cur;
      end else begin
        col_cnt_nxt = col_cur + dge_pkg::COL_W'(1);
        row_cnt_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // line memory clear after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + dge_pkg::COL_W'(1);
      if (clr_addr_r == dge_pkg::COL_W'(dge_pkg::MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // line entry: upper half two lines up, lower half one line up
  assign line_data = fwd_r ? fwd_data_r : ram_rdata;
  assign up1       = line_data[dge_pkg::PIX_W-1:0];
  assign up2       = line_data[dge_pkg::LINE_W-1:dge_pkg::PIX_W];
  assign wr_line   = {up1, s1_px_r};

  assign ram_we    = clr_busy_r | s1_v_r;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_col_r;
  assign ram_wdata = clr_busy_r ? '0 : wr_line;

  dge_ram #(
    .WIDTH(dge_pkg::LINE_W),
    .DEPTH(dge_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(col_cur),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      fwd_r  <= in_fire && s1_v_r && (s1_col_r == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r       <= in_pixel;
      s1_col_r      <= col_cur;
      s1_emit_r     <= emit;
      s1_meta_r.row <= row_cur - dge_pkg::POS_W'(1);
      s1_meta_r.col <= dge_pkg::POS_W'(col_cur) - dge_pkg::POS_W'(1);
    end
    fwd_data_r <= wr_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
    end else begin
      w_v_r <= s1_v_r & s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= s1_px_r;
      w_meta_r    <= s1_meta_r;
    end
  end

  assign win             = win_r;
  assign win_valid       = w_v_r;
  assign win_meta        = w_meta_r;
  assign status.clearing = clr_busy_r;
  assign status.s1_busy  = s1_v_r;
  assign status.win_busy = w_v_r;

  a_no_transfer_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !in_fire
  ) else $error("pixel transfer during line memory clear");

  a_forward_same_column: assert property (
    @(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_v_r && $past(s1_v_r) && (s1_col_r == $past(s1_col_r)))
  ) else $error("line forward without matching column");

endmodule

@@ rtl/dge_kernel.sv @@
// Per-channel diagonal kernel sums and the running edge total.
module dge_kernel (
  input  logic             clk,
  input  logic             rst_n,
  input  dge_pkg::window_t win,
  input  logic             win_valid,
  input  dge_pkg::meta_t   win_meta,
  output logic             res_valid,
  output dge_pkg::result_t res,
  output logic             busy
);

  logic signed [dge_pkg::KSUM_W-1:0] ks_r [dge_pkg::NUM_CH];
  logic signed [dge_pkg::KSUM_W-1:0] ks_nxt [dge_pkg::NUM_CH];
  logic                              ks_v_r;
  dge_pkg::meta_t                    ks_meta_r;
  logic [dge_pkg::EDGE_W-1:0]        edge_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_v_r <= 1'b0;
    end else begin
      ks_v_r <= win_valid;
    end
  end

  always_comb begin
    for (int c = 0; c < dge_pkg::NUM_CH; c++) begin
      ks_nxt[c] =
          $signed(dge_pkg::KSUM_W'(win[1][2][c*dge_pkg::CH_W +: dge_pkg::CH_W])
                + dge_pkg::KSUM_W'(win[2][1][c*dge_pkg::CH_W +: dge_pkg::CH_W])
                + (dge_pkg::KSUM_W'(win[2][2][c*dge_pkg::CH_W +: dge_pkg::CH_W]) << 1))
        - $signed(dge_pkg::KSUM_W'(win[0][1][c*dge_pkg::CH_W +: dge_pkg::CH_W])
                + dge_pkg::KSUM_W'(win[1][0][c*dge_pkg::CH_W +: dge_pkg::CH_W])
                + (dge_pkg::KSUM_W'(win[0][0][c*dge_pkg::CH_W +: dge_pkg::CH_W]) << 1));
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid) begin
      for (int c = 0; c < dge_pkg::NUM_CH; c++) begin
        ks_r[c] <= ks_nxt[c];
      end
      ks_meta_r <= win_meta;
    end
  end

  // total + |total| is zero for a negative total and twice it otherwise
  always_comb begin
    logic signed [dge_pkg::TOT_W-1:0] tot;
    logic signed [dge_pkg::TOT_W-1:0] t;
    logic [dge_pkg::TOT_W-1:0]        fin;
    tot = '0;
    for (int c = 0; c < dge_pkg::NUM_CH; c++) begin
      t   = tot + dge_pkg::TOT_W'(ks_r[c]);
      tot = (t < 0) ? '0 : (t <<< 1);
    end
    fin      = dge_pkg::TOT_W'(tot) << 2;
    edge_val = (fin > dge_pkg::EDGE_LIMIT) ? '0 : fin[dge_pkg::EDGE_W-1:0];
  end

  assign res_valid      = ks_v_r;
  assign res.edge_value = edge_val;
  assign res.row        = ks_meta_r.row;
  assign res.col        = ks_meta_r.col;
  assign busy           = ks_v_r;

endmodule

@@ rtl/dge_obuf.sv @@
// Result buffer between the pipeline and the output channel.
module dge_obuf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  dge_pkg::result_t            push_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dge_pkg::result_t            out_data,
  output logic [dge_pkg::OBUF_CW-1:0] count
);

  dge_pkg::result_t            mem_r [dge_pkg::OBUF_DEPTH];
  logic [dge_pkg::OBUF_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [dge_pkg::OBUF_CW-1:0] cnt_r, cnt_nxt;
  logic                        pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + dge_pkg::OBUF_CW'(1);
      2'b01:   cnt_nxt = cnt_r - dge_pkg::OBUF_CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + dge_pkg::OBUF_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + dge_pkg::OBUF_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != dge_pkg::OBUF_CW'(dge_pkg::OBUF_DEPTH))
  ) else $error("result pushed into full buffer");

  a_count_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    cnt_r <= dge_pkg::OBUF_CW'(dge_pkg::OBUF_DEPTH)
  ) else $error("result buffer count out of range");

endmodule

@@ rtl/diagonal_gradient_edge_3x3_unit.sv @@
// Top level of the diagonal gradient edge unit.
//
// Input channel (in_valid/in_ready): one packed BGR pixel per transfer in
// raster order; in_start_of_frame marks row 0, column 0 of a new frame.
// Output channel (out_valid/out_ready): one edge value per interior pixel
// with its row and column; border pixels produce no transfer.
// cfg_wr_en/cfg_wr_data write the line width; it applies from the next transfer.
// Pipeline: line memory read, window shift, kernel sums, then the edge total.
// Throughput: one pixel per cycle while in_ready is high; the line memory is
// read and written once per pixel, with a one-entry forward for back-to-back
// same column.
// Reset: the 1024-entry line memory is cleared one entry per cycle, so
// in_ready stays low until the clear is done; the width register and
// counters reset at once.
// Stall: an 8-entry result buffer absorbs the 3 pixels in flight;
// in_ready drops once buffered plus in-flight items would fill it.
module diagonal_gradient_edge_3x3_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dge_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dge_pkg::PIX_W-1:0]  in_pixel_bgr,
  input  logic                       in_start_of_frame,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dge_pkg::EDGE_W-1:0] out_edge_value,
  output logic [dge_pkg::POS_W-1:0]  out_row,
  output logic [dge_pkg::POS_W-1:0]  out_col
);

  logic                        in_fire;
  dge_pkg::window_t            win;
  logic                        win_valid;
  dge_pkg::meta_t              win_meta;
  dge_pkg::lw_status_t         lw_status;
  logic                        res_valid;
  dge_pkg::result_t            res;
  logic                        k_busy;
  dge_pkg::result_t            out_data;
  logic [dge_pkg::OBUF_CW-1:0] obuf_cnt;
  logic [dge_pkg::OBUF_CW:0]   occupancy;

  assign occupancy = (dge_pkg::OBUF_CW+1)'(obuf_cnt)
                   + (dge_pkg::OBUF_CW+1)'(lw_status.s1_busy)
                   + (dge_pkg::OBUF_CW+1)'(lw_status.win_busy)
                   + (dge_pkg::OBUF_CW+1)'(k_busy);
  assign in_ready  = !lw_status.clearing
                   && (occupancy < (dge_pkg::OBUF_CW+1)'(dge_pkg::OBUF_DEPTH));
  assign in_fire   = in_valid & in_ready;

  dge_line_window u_line_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_fire    (in_fire),
    .in_pixel   (in_pixel_bgr),
    .in_sof     (in_start_of_frame),
    .win        (win),
    .win_valid  (win_valid),
    .win_meta   (win_meta),
    .status     (lw_status)
  );

  dge_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .win      (win),
    .win_valid(win_valid),
    .win_meta (win_meta),
    .res_valid(res_valid),
    .res      (res),
    .busy     (k_busy)
  );

  dge_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .count    (obuf_cnt)
  );

  assign out_edge_value = out_data.edge_value;
  assign out_row        = out_data.row;
  assign out_col        = out_data.col;

endmodule
